// ----- rtl/tel_pkg.sv -----
// shared types, codes and constants of the transaction error log table
`default_nettype none

package tel_pkg;

    // table depth and queue depth defaults
    localparam int LOG_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;

    // count wrap point, wraps to one
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // command codes on the input word
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_COUNT = 2'd1;
    localparam logic [1:0] CMD_WORST = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // decoded operation
    typedef enum logic [1:0] {
        OP_ADD,
        OP_COUNT,
        OP_WORST,
        OP_CLEAR
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_OFF  = 2'd2
    } t_status;

    // engine states
    typedef enum logic [1:0] {
        ES_IDLE,
        ES_SCAN,
        ES_DONE
    } t_eng_state;

    // input word
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] register_quantity;
        logic [3:0]  error_kind;
    } t_in_word;

    // result word
    typedef struct packed {
        t_status     status;
        logic        found;
        logic [15:0] hit_count;
        logic [7:0]  entry_slave;
        logic [7:0]  entry_function;
        logic [15:0] entry_start;
        logic [15:0] entry_quantity;
        logic [3:0]  entry_error;
        logic [31:0] total_errors;
    } t_out_word;

    // transaction key
    typedef struct packed {
        logic [7:0]  slave;
        logic [7:0]  fcode;
        logic [15:0] start;
        logic [15:0] quantity;
    } t_key;

    // one table entry
    typedef struct packed {
        t_key        key;
        logic [15:0] count;
        logic [3:0]  err;
    } t_entry;

    // classified command between front and engine
    typedef struct packed {
        t_op        op;
        t_key       key;
        logic [3:0] err;
    } t_cmd_word;

endpackage

`default_nettype wire

// ----- rtl/tel_fifo.sv -----
// small synchronous queue with full and empty flags
`default_nettype none

module tel_fifo #(
    parameter int DEPTH = tel_pkg::QUEUE_DEPTH,
    parameter int WIDTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    // flags and handshakes
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // pointer and fill count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        end
        if (pop_ok) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tel_front.sv -----
// front end: accepts input words, decodes the command and queues it
`default_nettype none

module tel_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire tel_pkg::t_in_word i_item,
    output logic                   o_cmd_vld,
    output tel_pkg::t_cmd_word     o_cmd,
    input  wire logic              i_cmd_pop
);

    localparam int CMD_W = $bits(tel_pkg::t_cmd_word);

    tel_pkg::t_cmd_word cmd_in;
    logic [CMD_W-1:0]   cmd_q;
    logic               cmd_empty;

    // classify the incoming word
    always_comb begin
        cmd_in.key.slave    = i_item.slave_address;
        cmd_in.key.fcode    = i_item.function_code;
        cmd_in.key.start    = i_item.start_address;
        cmd_in.key.quantity = i_item.register_quantity;
        cmd_in.err          = i_item.error_kind;
        unique case (i_item.command)
            tel_pkg::CMD_ADD:   cmd_in.op = tel_pkg::OP_ADD;
            tel_pkg::CMD_COUNT: cmd_in.op = tel_pkg::OP_COUNT;
            tel_pkg::CMD_WORST: cmd_in.op = tel_pkg::OP_WORST;
            tel_pkg::CMD_CLEAR: cmd_in.op = tel_pkg::OP_CLEAR;
            default:            cmd_in.op = tel_pkg::OP_ADD;
        endcase
    end

    // command queue toward the engine
    tel_fifo #(
        .DEPTH (tel_pkg::QUEUE_DEPTH),
        .WIDTH (CMD_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (i_cmd_pop),
        .o_data  (cmd_q),
        .o_empty (cmd_empty)
    );

    assign o_cmd_vld = !cmd_empty;
    assign o_cmd     = tel_pkg::t_cmd_word'(cmd_q);

endmodule

`default_nettype wire

// ----- rtl/tel_engine.sv -----
// back end: table memory, sequential scan and result formation
`default_nettype none

module tel_engine #(
    parameter int LOG_DEPTH = tel_pkg::LOG_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire logic               i_cmd_vld,
    input  wire tel_pkg::t_cmd_word i_cmd,
    output logic                    o_cmd_pop,
    output logic                    o_res_push,
    output tel_pkg::t_out_word      o_res,
    input  wire logic               i_res_full
);

    localparam int IW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = $clog2(LOG_DEPTH + 1);

    tel_pkg::t_entry     r_mem [LOG_DEPTH];
    tel_pkg::t_entry     r_q;

    tel_pkg::t_eng_state r_state, n_state;
    logic [CW-1:0]       r_used, n_used;
    logic [31:0]         r_total, n_total;
    logic                r_log_enable;
    logic [CW-1:0]       r_issue, n_issue;
    logic                r_dv, n_dv;
    logic [IW-1:0]       r_didx, n_didx;
    tel_pkg::t_op        r_op, n_op;
    tel_pkg::t_key       r_key, n_key;
    logic [3:0]          r_err, n_err;
    tel_pkg::t_entry     r_best, n_best;
    logic                r_best_vld, n_best_vld;
    tel_pkg::t_out_word  r_res, n_res;

    logic                mem_we;
    logic [IW-1:0]       mem_wa;
    tel_pkg::t_entry     mem_wd;
    logic                mem_re;
    logic [IW-1:0]       mem_ra;
    logic                scan_rd;
    logic [15:0]         bump_count;

    // result word naming an entry
    function automatic tel_pkg::t_out_word f_report(input tel_pkg::t_entry e,
                                                    input logic [31:0] tot);
        tel_pkg::t_out_word w;
        w                = '0;
        w.status         = tel_pkg::ST_DONE;
        w.found          = 1'b1;
        w.hit_count      = e.count;
        w.entry_slave    = e.key.slave;
        w.entry_function = e.key.fcode;
        w.entry_start    = e.key.start;
        w.entry_quantity = e.key.quantity;
        w.entry_error    = e.err;
        w.total_errors   = tot;
        return w;
    endfunction

    // result word with no entry
    function automatic tel_pkg::t_out_word f_blank(input tel_pkg::t_status st,
                                                   input logic [31:0] tot);
        tel_pkg::t_out_word w;
        w              = '0;
        w.status       = st;
        w.total_errors = tot;
        return w;
    endfunction

    assign scan_rd    = (r_state == tel_pkg::ES_SCAN) && (r_issue < r_used);
    assign bump_count = (r_q.count != tel_pkg::COUNT_MAX) ? r_q.count + 16'd1 : 16'd1;

    // sequencer: next state, memory access and result
    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_total    = r_total;
        n_issue    = r_issue;
        n_dv       = 1'b0;
        n_didx     = r_didx;
        n_op       = r_op;
        n_key      = r_key;
        n_err      = r_err;
        n_best     = r_best;
        n_best_vld = r_best_vld;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_wa     = r_used[IW-1:0];
        mem_wd     = '0;
        mem_re     = 1'b0;
        mem_ra     = r_issue[IW-1:0];
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;

        unique case (r_state)
            tel_pkg::ES_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop  = 1'b1;
                    n_op       = i_cmd.op;
                    n_key      = i_cmd.key;
                    n_err      = i_cmd.err;
                    n_issue    = '0;
                    n_best_vld = 1'b0;
                    unique case (i_cmd.op)
                        tel_pkg::OP_ADD: begin
                            n_total = r_total + 32'd1;
                            if (r_used >= CW'(LOG_DEPTH)) begin
                                n_res   = f_blank(tel_pkg::ST_FULL, n_total);
                                n_state = tel_pkg::ES_DONE;
                            end else if (!r_log_enable) begin
                                n_res   = f_blank(tel_pkg::ST_OFF, n_total);
                                n_state = tel_pkg::ES_DONE;
                            end else begin
                                n_state = tel_pkg::ES_SCAN;
                            end
                        end
                        tel_pkg::OP_COUNT,
                        tel_pkg::OP_WORST: begin
                            if (r_used == '0) begin
                                n_res   = f_blank(tel_pkg::ST_DONE, r_total);
                                n_state = tel_pkg::ES_DONE;
                            end else begin
                                n_state = tel_pkg::ES_SCAN;
                            end
                        end
                        tel_pkg::OP_CLEAR: begin
                            n_used  = '0;
                            n_total = '0;
                            n_res   = f_blank(tel_pkg::ST_DONE, 32'd0);
                            n_state = tel_pkg::ES_DONE;
                        end
                        default: n_state = tel_pkg::ES_IDLE;
                    endcase
                end
            end

            tel_pkg::ES_SCAN: begin
                // issue the next read while checking the previous one
                if (scan_rd) begin
                    mem_re  = 1'b1;
                    n_dv    = 1'b1;
                    n_didx  = r_issue[IW-1:0];
                    n_issue = r_issue + CW'(1);
                end
                if (r_dv) begin
                    unique case (r_op)
                        tel_pkg::OP_ADD: begin
                            if (r_q.key == r_key) begin
                                mem_we       = 1'b1;
                                mem_wa       = r_didx;
                                mem_wd.key   = r_q.key;
                                mem_wd.count = bump_count;
                                mem_wd.err   = r_err;
                                n_res        = f_report(mem_wd, r_total);
                                n_state      = tel_pkg::ES_DONE;
                            end
                        end
                        tel_pkg::OP_COUNT: begin
                            if (r_q.key.start == r_key.start) begin
                                n_res   = f_report(r_q, r_total);
                                n_state = tel_pkg::ES_DONE;
                            end
                        end
                        tel_pkg::OP_WORST: begin
                            if (!r_best_vld || (r_q.count > r_best.count)) begin
                                n_best     = r_q;
                                n_best_vld = 1'b1;
                            end
                        end
                        default: n_state = tel_pkg::ES_SCAN;
                    endcase
                end else if (!scan_rd) begin
                    // every used entry seen
                    n_state = tel_pkg::ES_DONE;
                    unique case (r_op)
                        tel_pkg::OP_ADD: begin
                            mem_we       = 1'b1;
                            mem_wa       = r_used[IW-1:0];
                            mem_wd.key   = r_key;
                            mem_wd.count = 16'd0;
                            mem_wd.err   = r_err;
                            n_used       = r_used + CW'(1);
                            n_res        = f_report(mem_wd, r_total);
                        end
                        tel_pkg::OP_WORST: n_res = f_report(r_best, r_total);
                        tel_pkg::OP_COUNT: n_res = f_blank(tel_pkg::ST_DONE, r_total);
                        default:           n_res = f_blank(tel_pkg::ST_DONE, r_total);
                    endcase
                end
            end

            tel_pkg::ES_DONE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = tel_pkg::ES_IDLE;
                end
            end

            default: n_state = tel_pkg::ES_IDLE;
        endcase
    end

    assign o_res = r_res;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tel_pkg::ES_IDLE;
            r_used       <= '0;
            r_total      <= '0;
            r_log_enable <= 1'b0;
            r_dv         <= 1'b0;
            r_best_vld   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_total    <= n_total;
            r_dv       <= n_dv;
            r_best_vld <= n_best_vld;
            if (i_cfg_we) begin
                r_log_enable <= i_cfg_wdata;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_issue <= n_issue;
        r_didx  <= n_didx;
        r_op    <= n_op;
        r_key   <= n_key;
        r_err   <= n_err;
        r_best  <= n_best;
        r_res   <= n_res;
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_q <= r_mem[mem_ra];
        end
    end

    // fill count never passes the table depth
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(LOG_DEPTH))
        else $error("fill count beyond table depth");

    // clear empties the table and the total
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tel_pkg::ES_IDLE && i_cmd_vld && i_cmd.op == tel_pkg::OP_CLEAR)
        |=> (r_used == '0 && r_total == '0))
        else $error("clear left state behind");

    // every taken add bumps the total by one
    a_total_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tel_pkg::ES_IDLE && i_cmd_vld && i_cmd.op == tel_pkg::OP_ADD)
        |=> (r_total == $past(r_total) + 32'd1))
        else $error("total not bumped on add");

    // an append grows the table by exactly one entry
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tel_pkg::ES_SCAN && r_op == tel_pkg::OP_ADD && !r_dv && !scan_rd)
        |=> (r_used == $past(r_used) + CW'(1)))
        else $error("append did not grow the table");

    // a result leaves only from the done state
    a_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> (r_state == tel_pkg::ES_IDLE))
        else $error("result push outside done state");

endmodule

`default_nettype wire

// ----- rtl/transaction_error_log_table.sv -----
// Transaction error log table, top level.
// Input channel: a command word is taken when push is high and full is low;
// the front decodes it into a two-word command queue, so up to two commands
// can wait while the engine works. Result channel: while empty is low the
// oldest result word is on o_result and leaves when pop is high; a two-word
// result queue lets the engine finish the next command while a result waits.
// Configuration: i_cfg_we with i_cfg_wdata writes the log enable bit.
// Scanning: add, count lookup and worst report scan the used entries through
// the table memory's single read port, one entry a cycle. Refused adds,
// clear and queries on an empty table go straight to the result without a
// scan. One command is in the engine at a time; the next queued command
// starts in the cycle after the previous result leaves the engine.
// Reset: synchronous, active low; empties both queues, the table fill count
// and the total, and turns logging off. Table contents are not cleared; only
// entries below the fill count are ever read.
// Stalls: when the result queue is full the engine holds its finished result,
// then the command queue fills and full rises.
`default_nettype none

module transaction_error_log_table #(
    parameter int LOG_DEPTH = tel_pkg::LOG_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire tel_pkg::t_in_word i_item,
    output logic                   empty,
    input  wire logic              pop,
    output tel_pkg::t_out_word     o_result,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata
);

    localparam int RES_W = $bits(tel_pkg::t_out_word);

    logic               cmd_vld;
    tel_pkg::t_cmd_word cmd;
    logic               cmd_pop;
    logic               res_push;
    tel_pkg::t_out_word res;
    logic               res_full;
    logic [RES_W-1:0]   res_q;

    // front: accept and decode
    tel_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd),
        .i_cmd_pop (cmd_pop)
    );

    // back: table engine
    tel_engine #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_vld   (cmd_vld),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    // result queue
    tel_fifo #(
        .DEPTH (tel_pkg::QUEUE_DEPTH),
        .WIDTH (RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign o_result = tel_pkg::t_out_word'(res_q);

endmodule

`default_nettype wire
